### design/rsort_pkg.sv
// ---------------------------------------------------------------------------
// rsort_pkg
// Shared types, sizes and helpers for the record sort-by-score-sum block.
// ---------------------------------------------------------------------------
`default_nettype none

package rsort_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int SCORE_W     = 10;
  localparam int TAG_W       = 8;
  localparam int SUM_W       = 12;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] s1;
    logic [SCORE_W-1:0] s2;
    logic [SCORE_W-1:0] s3;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [TAG_W-1:0]   record_tag;
    logic [SCORE_W-1:0] score_first;
    logic [SCORE_W-1:0] score_second;
    logic [SCORE_W-1:0] score_third;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   out_tag;
    logic [SCORE_W-1:0] out_first;
    logic [SCORE_W-1:0] out_second;
    logic [SCORE_W-1:0] out_third;
    logic [SUM_W-1:0]   out_sum;
    logic               overflowed;
    logic               last_out;
  } out_item_t;

  // Sort key: sum of the three scores.
  function automatic logic [SUM_W-1:0] rec_sum(input rec_t r);
    logic [SUM_W-1:0] acc;
    acc = SUM_W'(r.s1) + SUM_W'(r.s2) + SUM_W'(r.s3);
    return acc;
  endfunction

endpackage

`default_nettype wire

### design/rsort_ram.sv
// ---------------------------------------------------------------------------
// rsort_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rsort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### design/record_sort_by_score_sum_core.sv
// ---------------------------------------------------------------------------
// record_sort_by_score_sum_core
// Loads a set of records, selection-sorts them by descending score sum and
// streams them out in sorted order.
// ---------------------------------------------------------------------------
// Records are taken one per cycle into a 16-entry RAM until a request marked
// last arrives; records beyond the capacity are dropped and every result of
// that set carries the overflow flag. The block then stalls its input while
// a sequencer sorts the set with one adder/comparator and one RAM read port:
// for each position i it reads and captures that record, scans the
// remaining records for the largest sum, drains the scan and then writes
// the two swapped records. Each result then goes through a RAM read, an
// output load and a handoff that waits while the output is stalled; the
// input stays stalled until the last result of the set is handed off.
// Ties keep the first-found record, as a strict-compare selection sort does.
// ---------------------------------------------------------------------------
`default_nettype none

module record_sort_by_score_sum_core
  import rsort_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_RDI   = 9'b000000010,
    S_GETI  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_SWAP1 = 9'b000010000,
    S_SWAP2 = 9'b000100000,
    S_EMRD  = 9'b001000000,
    S_EMLD  = 9'b010000000,
    S_EMWT  = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [SUM_W-1:0] best_sum_r, best_sum_nxt;
  rec_t             best_rec_r, best_rec_nxt;
  rec_t             rec_i_r, rec_i_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             in_acc;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_rec;
  logic [IDX_W-1:0] rd_addr;
  logic [REC_W-1:0] rd_data;
  rec_t             rd_rec;
  logic [SUM_W-1:0] rd_sum;
  rec_t             in_rec;
  logic             issue;

  rsort_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (REC_W'(wr_rec)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_rec   = rec_t'(rd_data);
  assign rd_sum   = rec_sum(rd_rec);
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = (j_r < count_r);

  always_comb begin
    in_rec.tag = in_data.record_tag;
    in_rec.s1  = in_data.score_first;
    in_rec.s2  = in_data.score_second;
    in_rec.s3  = in_data.score_third;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    best_idx_nxt  = best_idx_r;
    best_sum_nxt  = best_sum_r;
    best_rec_nxt  = best_rec_r;
    rec_i_nxt     = rec_i_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_rec        = in_rec;
    rd_addr       = i_r[IDX_W-1:0];

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_RECORDS)) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            i_nxt = '0;
            k_nxt = '0;
            if (count_nxt >= CNT_W'(2)) begin
              state_nxt = S_RDI;
            end else begin
              state_nxt = S_EMRD;
            end
          end
        end
      end
      S_RDI: begin
        rd_addr   = i_r[IDX_W-1:0];
        state_nxt = S_GETI;
      end
      S_GETI: begin
        rec_i_nxt    = rd_rec;
        best_rec_nxt = rd_rec;
        best_sum_nxt = rd_sum;
        best_idx_nxt = i_r[IDX_W-1:0];
        j_nxt        = i_r + CNT_W'(1);
        cmp_vld_nxt  = 1'b0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        // issue one read per cycle, compare the data that returns in the next cycle
        rd_addr = j_r[IDX_W-1:0];
        if (cmp_vld_r && (rd_sum > best_sum_r)) begin
          best_rec_nxt = rd_rec;
          best_sum_nxt = rd_sum;
          best_idx_nxt = cmp_idx_r;
        end
        cmp_vld_nxt = issue;
        cmp_idx_nxt = j_r[IDX_W-1:0];
        if (issue) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          state_nxt = S_SWAP1;
        end
      end
      S_SWAP1: begin
        wr_en     = 1'b1;
        wr_addr   = i_r[IDX_W-1:0];
        wr_rec    = best_rec_r;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = best_idx_r;
        wr_rec  = rec_i_r;
        i_nxt   = i_r + CNT_W'(1);
        if ((i_nxt + CNT_W'(1)) < count_r) begin
          state_nxt = S_RDI;
        end else begin
          state_nxt = S_EMRD;
        end
      end
      S_EMRD: begin
        rd_addr   = k_r[IDX_W-1:0];
        state_nxt = S_EMLD;
      end
      S_EMLD: begin
        out_nxt.out_tag    = rd_rec.tag;
        out_nxt.out_first  = rd_rec.s1;
        out_nxt.out_second = rd_rec.s2;
        out_nxt.out_third  = rd_rec.s3;
        out_nxt.out_sum    = rd_sum;
        out_nxt.overflowed = ovf_r;
        out_nxt.last_out   = ((k_r + CNT_W'(1)) == count_r);
        out_valid_nxt      = 1'b1;
        state_nxt          = S_EMWT;
      end
      S_EMWT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_out) begin
            // drop the set and start loading the next one
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_EMRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_sum_r <= best_sum_nxt;
    best_rec_r <= best_rec_nxt;
    rec_i_r    <= rec_i_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### design/rsort_chk.sv
// ---------------------------------------------------------------------------
// rsort_chk
// Port-level checks for the record sort core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rsort_chk
  import rsort_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic [SUM_W-1:0] chk_sum;

  assign chk_sum = SUM_W'(out_data.out_first) + SUM_W'(out_data.out_second)
                 + SUM_W'(out_data.out_third);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // the key always matches the scores it came with
  a_sum_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_sum == chk_sum))
    else $error("out_sum does not match scores");

  // no new request is taken while results are pending
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while emitting");

  // reset leaves the block ready to load
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("not idle after reset");

endmodule

bind record_sort_by_score_sum_core rsort_chk u_rsort_chk (.*);

`default_nettype wire
